@@ rtl/cpra_pkg.sv @@
// Shared types and codes for the contiguous page-run allocator.
// Holds page mark codes, status codes, request kinds, register indexes and
// the configuration word type. No dependencies.
package cpra_pkg;

   localparam int unsigned PAGE_W  = 20;
   localparam int unsigned COUNT_W = 13;
   localparam int unsigned MARK_W  = 3;
   localparam int unsigned CSR_IDX_W = 2;

   typedef logic [PAGE_W-1:0]    page_type;
   typedef logic [COUNT_W-1:0]   count_type;
   typedef logic [MARK_W-1:0]    mark_type;
   typedef logic [2:0]           status_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // Per-page marks
   localparam mark_type MARK_FREE  = 3'd0;
   localparam mark_type MARK_USED  = 3'd1;
   localparam mark_type MARK_START = 3'd2;
   localparam mark_type MARK_END   = 3'd3;
   localparam mark_type MARK_BOTH  = 3'd4;

   // Result status codes
   localparam status_type ST_OK          = 3'd0;
   localparam status_type ST_EXHAUSTED   = 3'd1;
   localparam status_type ST_BAD_COUNT   = 3'd2;
   localparam status_type ST_NOT_ALLOC   = 3'd3;
   localparam status_type ST_BAD_MARKS   = 3'd4;
   localparam status_type ST_OUT_OF_HEAP = 3'd5;

   // Request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // Register indexes
   localparam csr_idx_type CSR_HEAP_BASE = 2'd0;
   localparam csr_idx_type CSR_RES_FIRST = 2'd1;
   localparam csr_idx_type CSR_RES_LAST  = 2'd2;

   // Register reset values
   localparam page_type HEAP_BASE_RST = 20'h00000;
   localparam page_type RES_FIRST_RST = 20'hD0000;
   localparam page_type RES_LAST_RST  = 20'hDFFFF;

   typedef struct packed {
      page_type heap_base;
      page_type res_first;
      page_type res_last;
   } cfg_type;

endpackage

@@ rtl/cpra_mark_ram.sv @@
// Page mark store: one write port, one read port, registered read data.
// Depends on cpra_pkg for the mark type.
module cpra_mark_ram #(
   parameter int unsigned DEPTH  = 4096,
   parameter int unsigned ADDR_W = 12
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  cpra_pkg::mark_type  wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output cpra_pkg::mark_type  rd_data
);

   cpra_pkg::mark_type mem [DEPTH];
   cpra_pkg::mark_type rd_data_ff;

   // Write one mark
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/cpra_page_check.sv @@
// Decides whether a heap page counts as free: its mark is free and its
// absolute page lies outside the reserved window. Depends on cpra_pkg.
module cpra_page_check #(
   parameter int unsigned IDX_W = 12
) (
   input  cpra_pkg::cfg_type   cfg,
   input  logic [IDX_W-1:0]    idx,
   input  cpra_pkg::mark_type  mark,
   output logic                page_free
);

   cpra_pkg::page_type abs_page;
   logic               in_window;

   // Absolute page, wrapped to the page width
   assign abs_page = cfg.heap_base + cpra_pkg::PAGE_W'(idx);

   // An inverted window is empty
   assign in_window = (cfg.res_first <= cfg.res_last) &&
                      (abs_page >= cfg.res_first) && (abs_page <= cfg.res_last);

   assign page_free = (mark == cpra_pkg::MARK_FREE) && !in_window;

endmodule

@@ rtl/contiguous_page_run_allocator.sv @@
// Next-fit contiguous page-run allocator over a page mark memory.
// Allocate: scans pages from the search pointer (up to about 2*HEAP_PAGES),
// then marks the run page by page; result strobe in the cycle after the
// last mark. Free: walks the run. Zero count and out-of-heap free answer
// from idle. One request at a time; the mark memory's single read port
// paces the scan. Reset: clearing pass over the marks, busy high meanwhile.
module contiguous_page_run_allocator #(
   parameter int unsigned HEAP_PAGES = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   // Request
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_kind,
   input  cpra_pkg::count_type          req_page_count,
   input  cpra_pkg::page_type           req_release_page,
   // Result
   output logic                         rsp_strobe,
   output cpra_pkg::status_type         rsp_status,
   output cpra_pkg::page_type           rsp_first_page,
   output cpra_pkg::count_type          rsp_pages_released,
   // Configuration
   input  logic                         csr_we,
   input  cpra_pkg::csr_idx_type        csr_index,
   input  cpra_pkg::page_type           csr_wdata
);

   localparam int unsigned IDX_W = $clog2(HEAP_PAGES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HEAP_PAGES - 1);
   localparam logic [cpra_pkg::PAGE_W:0] HEAP_SPAN = (cpra_pkg::PAGE_W + 1)'(HEAP_PAGES);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_MARK  = 3'd3;
   localparam logic [2:0] S_FREE  = 3'd4;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   function automatic cpra_pkg::count_type count_type_one();
      return cpra_pkg::COUNT_W'(1);
   endfunction

   // Control registers
   logic [2:0]          state_ff, state_in;
   cpra_pkg::cfg_type   cfg_ff;
   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    scan_addr_ff, scan_addr_in;
   logic [IDX_W-1:0]    start_ff, start_in;
   cpra_pkg::count_type run_ff, run_in;
   cpra_pkg::count_type count_ff, count_in;
   cpra_pkg::count_type step_ff, step_in;
   logic                wrapped_ff, wrapped_in;
   logic                first_ff, first_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   // Result payload
   cpra_pkg::status_type rsp_status_ff, rsp_status_in;
   cpra_pkg::page_type   rsp_first_page_ff, rsp_first_page_in;
   cpra_pkg::count_type  rsp_released_ff, rsp_released_in;

   // Memory ports
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   cpra_pkg::mark_type  wr_data;
   logic [IDX_W-1:0]    rd_addr;
   cpra_pkg::mark_type  rd_data;

   // Helpers
   logic                page_free;
   cpra_pkg::page_type  rel_diff;
   logic                rel_in_heap;
   cpra_pkg::count_type run_inc;
   logic [IDX_W-1:0]    run_start;
   cpra_pkg::count_type step_inc;
   logic                last_step;

   cpra_mark_ram #(
      .DEPTH  (HEAP_PAGES),
      .ADDR_W (IDX_W)
   ) u_marks (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cpra_page_check #(
      .IDX_W (IDX_W)
   ) u_check (
      .cfg       (cfg_ff),
      .idx       (idx_ff),
      .mark      (rd_data),
      .page_free (page_free)
   );

   // Free request range check
   assign rel_diff    = req_release_page - cfg_ff.heap_base;
   assign rel_in_heap = (req_release_page >= cfg_ff.heap_base) &&
                        ({1'b0, rel_diff} < HEAP_SPAN);

   assign run_inc   = run_ff + 1'b1;
   assign run_start = (run_ff == '0) ? idx_ff : start_ff;
   assign step_inc  = step_ff + 1'b1;
   assign last_step = (step_ff == count_ff - 1'b1);

   // Sequencer
   always_comb begin
      state_in          = state_ff;
      ptr_in            = ptr_ff;
      idx_in            = idx_ff;
      scan_addr_in      = scan_addr_ff;
      start_in          = start_ff;
      run_in            = run_ff;
      count_in          = count_ff;
      step_in           = step_ff;
      wrapped_in        = wrapped_ff;
      first_in          = first_ff;
      rsp_strobe_in     = 1'b0;
      rsp_status_in     = rsp_status_ff;
      rsp_first_page_in = rsp_first_page_ff;
      rsp_released_in   = rsp_released_ff;
      wr_en             = 1'b0;
      wr_addr           = idx_ff;
      wr_data           = cpra_pkg::MARK_FREE;
      rd_addr           = ptr_ff;

      unique case (state_ff)
         S_CLEAR: begin
            // Sweep the marks to free
            wr_en  = 1'b1;
            idx_in = next_idx(idx_ff);
            if (idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            rd_addr = (req_kind == cpra_pkg::KIND_FREE) ? rel_diff[IDX_W-1:0] : ptr_ff;
            if (start) begin
               rsp_first_page_in = '0;
               rsp_released_in   = '0;
               if (req_kind == cpra_pkg::KIND_ALLOC) begin
                  if (req_page_count == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = cpra_pkg::ST_BAD_COUNT;
                  end else begin
                     state_in     = S_SCAN;
                     idx_in       = ptr_ff;
                     scan_addr_in = next_idx(ptr_ff);
                     run_in       = '0;
                     wrapped_in   = 1'b0;
                     count_in     = req_page_count;
                  end
               end else begin
                  if (!rel_in_heap) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = cpra_pkg::ST_OUT_OF_HEAP;
                  end else begin
                     state_in = S_FREE;
                     idx_in   = rel_diff[IDX_W-1:0];
                     step_in  = '0;
                     first_in = 1'b1;
                  end
               end
            end
         end

         S_SCAN: begin
            // Stream reads ahead; evaluate the page whose mark just arrived
            rd_addr      = scan_addr_ff;
            scan_addr_in = next_idx(scan_addr_ff);
            idx_in       = scan_addr_ff;
            if (page_free) begin
               start_in = run_start;
               run_in   = run_inc;
            end else begin
               run_in = '0;
            end
            if (page_free && (run_inc == count_ff)) begin
               state_in = S_MARK;
               idx_in   = run_start;
               step_in  = '0;
            end else if (idx_ff == LAST_IDX) begin
               // Drop the partial run at the wrap
               run_in = '0;
               if (wrapped_ff) begin
                  state_in      = S_IDLE;
                  ptr_in        = '0;
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = cpra_pkg::ST_EXHAUSTED;
               end else begin
                  wrapped_in = 1'b1;
               end
            end
         end

         S_MARK: begin
            // Write start, middle and end marks, or a both mark for a one-page run
            wr_en = 1'b1;
            priority if (count_ff == count_type_one()) begin
               wr_data = cpra_pkg::MARK_BOTH;
            end else if (step_ff == '0) begin
               wr_data = cpra_pkg::MARK_START;
            end else if (last_step) begin
               wr_data = cpra_pkg::MARK_END;
            end else begin
               wr_data = cpra_pkg::MARK_USED;
            end
            step_in = step_inc;
            idx_in  = next_idx(idx_ff);
            if (last_step) begin
               state_in          = S_IDLE;
               ptr_in            = next_idx(idx_ff);
               rsp_strobe_in     = 1'b1;
               rsp_status_in     = cpra_pkg::ST_OK;
               rsp_first_page_in = cfg_ff.heap_base + cpra_pkg::PAGE_W'(start_ff);
            end
         end

         S_FREE: begin
            // Clear the current page while the next mark is read
            rd_addr = next_idx(idx_ff);
            unique case (rd_data)
               cpra_pkg::MARK_FREE: begin
                  state_in        = S_IDLE;
                  rsp_strobe_in   = 1'b1;
                  rsp_status_in   = cpra_pkg::ST_NOT_ALLOC;
                  rsp_released_in = step_ff;
               end
               cpra_pkg::MARK_USED, cpra_pkg::MARK_START: begin
                  if ((rd_data == cpra_pkg::MARK_START) && !first_ff) begin
                     state_in        = S_IDLE;
                     rsp_strobe_in   = 1'b1;
                     rsp_status_in   = cpra_pkg::ST_BAD_MARKS;
                     rsp_released_in = step_ff;
                  end else begin
                     wr_en = 1'b1;
                     if (idx_ff == LAST_IDX) begin
                        state_in        = S_IDLE;
                        rsp_strobe_in   = 1'b1;
                        rsp_status_in   = cpra_pkg::ST_OUT_OF_HEAP;
                        rsp_released_in = step_inc;
                     end else begin
                        idx_in   = next_idx(idx_ff);
                        step_in  = step_inc;
                        first_in = 1'b0;
                     end
                  end
               end
               cpra_pkg::MARK_END, cpra_pkg::MARK_BOTH: begin
                  state_in      = S_IDLE;
                  rsp_strobe_in = 1'b1;
                  if ((rd_data == cpra_pkg::MARK_END) == first_ff) begin
                     rsp_status_in   = cpra_pkg::ST_BAD_MARKS;
                     rsp_released_in = step_ff;
                  end else begin
                     wr_en           = 1'b1;
                     rsp_status_in   = cpra_pkg::ST_OK;
                     rsp_released_in = step_inc;
                  end
               end
               default: begin
                  state_in        = S_IDLE;
                  rsp_strobe_in   = 1'b1;
                  rsp_status_in   = cpra_pkg::ST_BAD_MARKS;
                  rsp_released_in = step_ff;
               end
            endcase
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         ptr_ff        <= '0;
         idx_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         idx_ff        <= idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.heap_base <= cpra_pkg::HEAP_BASE_RST;
         cfg_ff.res_first <= cpra_pkg::RES_FIRST_RST;
         cfg_ff.res_last  <= cpra_pkg::RES_LAST_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            cpra_pkg::CSR_HEAP_BASE: cfg_ff.heap_base <= csr_wdata;
            cpra_pkg::CSR_RES_FIRST: cfg_ff.res_first <= csr_wdata;
            cpra_pkg::CSR_RES_LAST:  cfg_ff.res_last  <= csr_wdata;
            default: begin
               // Drop writes beyond the register list
            end
         endcase
      end
   end

   // Working and result payload
   always_ff @(posedge clock) begin
      scan_addr_ff      <= scan_addr_in;
      start_ff          <= start_in;
      run_ff            <= run_in;
      count_ff          <= count_in;
      step_ff           <= step_in;
      wrapped_ff        <= wrapped_in;
      first_ff          <= first_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_first_page_ff <= rsp_first_page_in;
      rsp_released_ff   <= rsp_released_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_first_page     = rsp_first_page_ff;
   assign rsp_pages_released = rsp_released_ff;

   // A result always lands as the sequencer returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while sequencer busy");

   // Failed requests report no page
   a_fail_no_page: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != cpra_pkg::ST_OK)) |-> (rsp_first_page == '0))
      else $error("failed request reports a first page");

   // A zero count answers in the next cycle
   a_zero_count: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == cpra_pkg::KIND_ALLOC) && (req_page_count == '0))
      |=> (rsp_strobe && (rsp_status == cpra_pkg::ST_BAD_COUNT)))
      else $error("zero count not rejected at once");

   // A found run never crosses the heap end while being marked
   a_mark_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK) |-> (idx_ff >= start_ff))
      else $error("run marking wrapped past heap end");

endmodule

@@ bench/contiguous_page_run_allocator_tb.sv @@
// Self-checking bench for the next-fit contiguous page-run allocator.
// Predicts each result word from its own page mark table and compares in order.
// Depends on cpra_pkg and the contiguous_page_run_allocator top level.
module contiguous_page_run_allocator_tb;

   localparam int unsigned HEAP_PAGES   = 4096;
   localparam int unsigned RANDOM_TOTAL = 1762;
   // Clearing pass, long wrapped scans of failed allocations and idle gaps,
   // taken several times over
   localparam int unsigned CYCLE_LIMIT  = 100_000_000;
   localparam int unsigned PAGE_SPAN    = 32'h100000;

   typedef struct packed {
      cpra_pkg::status_type status;
      cpra_pkg::page_type   first_page;
      cpra_pkg::count_type  released;
   } result_word_type;

   // Mirror of the allocator state plus the in-order store of predicted words
   class alloc_result_checker;
      cpra_pkg::mark_type marks [HEAP_PAGES];
      int unsigned        search_ptr;
      cpra_pkg::page_type heap_base;
      cpra_pkg::page_type res_first;
      cpra_pkg::page_type res_last;
      int unsigned        used_pages;
      int unsigned        live_runs [$];
      result_word_type    expected_words [$];
      int unsigned        errors;

      function new();
         foreach (marks[i]) marks[i] = cpra_pkg::MARK_FREE;
         search_ptr = 0;
         heap_base  = cpra_pkg::HEAP_BASE_RST;
         res_first  = cpra_pkg::RES_FIRST_RST;
         res_last   = cpra_pkg::RES_LAST_RST;
         used_pages = 0;
         errors     = 0;
      endfunction

      function void set_register(cpra_pkg::csr_idx_type idx, cpra_pkg::page_type data);
         case (idx)
            cpra_pkg::CSR_HEAP_BASE: heap_base = data;
            cpra_pkg::CSR_RES_FIRST: res_first = data;
            cpra_pkg::CSR_RES_LAST:  res_last  = data;
            default: ;
         endcase
      endfunction

      // A page is open when unmarked and outside a non-empty reserved window
      function bit page_open(int unsigned idx);
         cpra_pkg::page_type abs_page;
         abs_page = cpra_pkg::page_type'(heap_base + idx);
         if (marks[idx] != cpra_pkg::MARK_FREE) return 1'b0;
         if (res_first <= res_last && abs_page >= res_first && abs_page <= res_last)
            return 1'b0;
         return 1'b1;
      endfunction

      function result_word_type predict_alloc(cpra_pkg::count_type cnt);
         result_word_type w;
         int unsigned     ptr, run, first, i;
         bit              wrapped, exhausted;
         w = '0;
         if (cnt == 0) begin
            w.status = cpra_pkg::ST_BAD_COUNT;
            return w;
         end
         ptr = search_ptr;
         run = 0;
         first = 0;
         wrapped = 1'b0;
         exhausted = 1'b0;
         // Scan from the pointer; drop the partial run at the wrap, give up on the second
         while (run < cnt && !exhausted) begin
            if (page_open(ptr)) begin
               if (run == 0) first = ptr;
               run++;
            end else begin
               run = 0;
            end
            if (run < cnt) begin
               ptr++;
               if (ptr >= HEAP_PAGES) begin
                  ptr = 0;
                  run = 0;
                  if (wrapped) exhausted = 1'b1;
                  wrapped = 1'b1;
               end
            end
         end
         if (exhausted) begin
            search_ptr = 0;
            w.status = cpra_pkg::ST_EXHAUSTED;
            return w;
         end
         // Mark the run and advance the pointer past it
         if (cnt == 1) begin
            marks[first] = cpra_pkg::MARK_BOTH;
         end else begin
            for (i = 0; i < cnt; i++)
               marks[first + i] = (i == 0) ? cpra_pkg::MARK_START :
                                  (i == cnt - 1) ? cpra_pkg::MARK_END : cpra_pkg::MARK_USED;
         end
         used_pages += cnt;
         search_ptr = first + cnt;
         if (search_ptr >= HEAP_PAGES) search_ptr = 0;
         live_runs.push_back(first);
         w.status = cpra_pkg::ST_OK;
         w.first_page = cpra_pkg::page_type'(heap_base + first);
         return w;
      endfunction

      function result_word_type predict_free(cpra_pkg::page_type rel_page);
         result_word_type    w;
         int unsigned        idx, released;
         cpra_pkg::mark_type m;
         bit                 first, done, bad;
         w = '0;
         if (rel_page < heap_base ||
             (int'(rel_page) - int'(heap_base)) >= int'(HEAP_PAGES)) begin
            w.status = cpra_pkg::ST_OUT_OF_HEAP;
            return w;
         end
         idx = int'(rel_page) - int'(heap_base);
         released = 0;
         first = 1'b1;
         done = 1'b0;
         // Walk the run, clearing marks until its end or a bad page
         while (!done) begin
            if (idx >= HEAP_PAGES) begin
               w.status = cpra_pkg::ST_OUT_OF_HEAP;
               done = 1'b1;
            end else begin
               m = marks[idx];
               bad = (m == cpra_pkg::MARK_START || m == cpra_pkg::MARK_BOTH) ? !first :
                     (m == cpra_pkg::MARK_END) ? first : (m != cpra_pkg::MARK_USED);
               if (m == cpra_pkg::MARK_FREE) begin
                  w.status = cpra_pkg::ST_NOT_ALLOC;
                  done = 1'b1;
               end else if (bad) begin
                  w.status = cpra_pkg::ST_BAD_MARKS;
                  done = 1'b1;
               end else begin
                  marks[idx] = cpra_pkg::MARK_FREE;
                  used_pages--;
                  released++;
                  if (m == cpra_pkg::MARK_BOTH || m == cpra_pkg::MARK_END) begin
                     w.status = cpra_pkg::ST_OK;
                     done = 1'b1;
                  end else begin
                     idx++;
                     first = 1'b0;
                  end
               end
            end
         end
         w.released = cpra_pkg::count_type'(released);
         return w;
      endfunction

      function void note_request(logic kind, cpra_pkg::count_type cnt,
                                 cpra_pkg::page_type rel_page);
         if (kind == cpra_pkg::KIND_ALLOC) expected_words.push_back(predict_alloc(cnt));
         else expected_words.push_back(predict_free(rel_page));
      endfunction

      function void check_word(cpra_pkg::status_type st, cpra_pkg::page_type fp,
                               cpra_pkg::count_type rel);
         result_word_type w;
         if (expected_words.size() == 0) begin
            $error("result word with no request waiting: status %0d", st);
            errors++;
            return;
         end
         w = expected_words.pop_front();
         if (st !== w.status) begin
            $error("status expected %0d actual %0d", w.status, st);
            errors++;
         end
         if (fp !== w.first_page) begin
            $error("first_page expected %05h actual %05h", w.first_page, fp);
            errors++;
         end
         if (rel !== w.released) begin
            $error("pages_released expected %0d actual %0d", w.released, rel);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return expected_words.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_kind;
   cpra_pkg::count_type   req_page_count;
   cpra_pkg::page_type    req_release_page;
   logic                  rsp_strobe;
   cpra_pkg::status_type  rsp_status;
   cpra_pkg::page_type    rsp_first_page;
   cpra_pkg::count_type   rsp_pages_released;
   logic                  csr_we;
   cpra_pkg::csr_idx_type csr_index;
   cpra_pkg::page_type    csr_wdata;

   alloc_result_checker tracker;
   int unsigned         idle_pct;
   int unsigned         items_sent;
   int unsigned         cycle_count;

   contiguous_page_run_allocator #(.HEAP_PAGES(HEAP_PAGES)) uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_page_count     (req_page_count),
      .req_release_page   (req_release_page),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_first_page     (rsp_first_page),
      .rsp_pages_released (rsp_pages_released),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Check every strobed result word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_strobe) tracker.check_word(rsp_status, rsp_first_page, rsp_pages_released);
   end

   // Bound the run length
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Present one request and hold it until the block takes it
   task automatic send_request(logic kind, cpra_pkg::count_type cnt,
                               cpra_pkg::page_type rel_page);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start            = 1'b1;
      req_kind         = kind;
      req_page_count   = cnt;
      req_release_page = rel_page;
      do @(posedge clock); while (busy !== 1'b0);
      tracker.note_request(kind, cnt, rel_page);
   endtask

   // Drop start and wait until the block is idle with nothing outstanding
   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      while (tracker.pending() != 0 || busy !== 1'b0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(cpra_pkg::csr_idx_type idx, cpra_pkg::page_type data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      tracker.set_register(idx, data);
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   task automatic configure(cpra_pkg::page_type base, cpra_pkg::page_type rfirst,
                            cpra_pkg::page_type rlast);
      wait_idle();
      write_csr(cpra_pkg::CSR_HEAP_BASE, base);
      write_csr(cpra_pkg::CSR_RES_FIRST, rfirst);
      write_csr(cpra_pkg::CSR_RES_LAST, rlast);
   endtask

   // Free a tracked run; drop it from tracking unless asked to keep it
   task automatic free_tracked_run(bit keep);
      int unsigned k, idx, abs_page;
      k = $urandom_range(tracker.live_runs.size() - 1);
      idx = tracker.live_runs[k];
      abs_page = int'(tracker.heap_base) + idx;
      // Keep runs that the current base cannot reach without wrapping
      if (!keep && abs_page < PAGE_SPAN) tracker.live_runs.delete(k);
      send_request(cpra_pkg::KIND_FREE, cpra_pkg::count_type'($urandom),
                   cpra_pkg::page_type'(abs_page));
   endtask

   task automatic random_item();
      int unsigned         pick;
      cpra_pkg::count_type cnt;
      cpra_pkg::page_type  rel_page;
      idle_pct = (items_sent < RANDOM_TOTAL / 3) ? 10 :
                 (items_sent < 2 * RANDOM_TOTAL / 3) ? 59 : 0;
      items_sent++;
      pick = $urandom_range(99);
      if (pick < 80) begin
         // Well-formed traffic: small allocations and frees of known runs
         if (tracker.used_pages > 2400) begin
            if (tracker.live_runs.size() != 0) free_tracked_run(1'b0);
            else send_request(cpra_pkg::KIND_FREE, cpra_pkg::count_type'($urandom),
                              cpra_pkg::page_type'(tracker.heap_base +
                                                   $urandom_range(HEAP_PAGES - 1)));
         end else if (tracker.live_runs.size() == 0 || $urandom_range(99) < 55) begin
            cnt = cpra_pkg::count_type'(($urandom_range(99) < 85) ? $urandom_range(8, 1)
                                                                  : $urandom_range(64, 9));
            send_request(cpra_pkg::KIND_ALLOC, cnt, cpra_pkg::page_type'($urandom));
         end else begin
            free_tracked_run(1'b0);
         end
      end else begin
         // Noise: bad counts, large runs, stray and broken frees
         case ($urandom_range(6))
            0: send_request(cpra_pkg::KIND_ALLOC, '0, cpra_pkg::page_type'($urandom));
            1: begin
               cnt = cpra_pkg::count_type'(($urandom_range(9) == 0)
                                           ? $urandom_range(8191, 1024)
                                           : $urandom_range(512, 65));
               send_request(cpra_pkg::KIND_ALLOC, cnt, cpra_pkg::page_type'($urandom));
            end
            2: send_request(cpra_pkg::KIND_FREE, cpra_pkg::count_type'($urandom),
                            cpra_pkg::page_type'($urandom));
            3: send_request(cpra_pkg::KIND_FREE, cpra_pkg::count_type'($urandom),
                            cpra_pkg::page_type'(tracker.heap_base +
                                                 $urandom_range(HEAP_PAGES - 1)));
            4: begin
               rel_page = $urandom_range(1)
                          ? cpra_pkg::page_type'(tracker.heap_base + HEAP_PAGES)
                          : cpra_pkg::page_type'(tracker.heap_base - 1);
               send_request(cpra_pkg::KIND_FREE, cpra_pkg::count_type'($urandom), rel_page);
            end
            5: begin
               if (tracker.live_runs.size() == 0) begin
                  send_request(cpra_pkg::KIND_ALLOC, '0, cpra_pkg::page_type'($urandom));
               end else begin
                  rel_page = cpra_pkg::page_type'(tracker.heap_base +
                             tracker.live_runs[$urandom_range(tracker.live_runs.size() - 1)]
                             + 1);
                  send_request(cpra_pkg::KIND_FREE, cpra_pkg::count_type'($urandom),
                               rel_page);
               end
            end
            default: begin
               if (tracker.live_runs.size() == 0)
                  send_request(cpra_pkg::KIND_ALLOC, cpra_pkg::count_type'(1), '0);
               else free_tracked_run(1'b1);
            end
         endcase
      end
   endtask

   task automatic random_items(int unsigned n);
      repeat (n) random_item();
   endtask

   initial begin
      tracker          = new();
      reset            = 1'b1;
      start            = 1'b0;
      req_kind         = cpra_pkg::KIND_ALLOC;
      req_page_count   = '0;
      req_release_page = '0;
      csr_we           = 1'b0;
      csr_index        = cpra_pkg::CSR_HEAP_BASE;
      csr_wdata        = '0;
      idle_pct         = 10;
      items_sent       = 0;
      cycle_count      = 0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Let the clearing pass finish
      wait_idle();

      // Directed: bad count, whole-heap run, run marks, partial frees, wrap, edges
      send_request(cpra_pkg::KIND_ALLOC, '0, '0);
      send_request(cpra_pkg::KIND_ALLOC, cpra_pkg::count_type'(4096), '0);
      send_request(cpra_pkg::KIND_FREE, '0, 20'h00000);
      send_request(cpra_pkg::KIND_ALLOC, cpra_pkg::count_type'(1), '0);
      send_request(cpra_pkg::KIND_FREE, '0, 20'h00000);
      send_request(cpra_pkg::KIND_FREE, '0, 20'h00000);
      send_request(cpra_pkg::KIND_ALLOC, cpra_pkg::count_type'(3), '0);
      send_request(cpra_pkg::KIND_FREE, '0, 20'h00002);
      send_request(cpra_pkg::KIND_FREE, '0, 20'h00001);
      send_request(cpra_pkg::KIND_ALLOC, cpra_pkg::count_type'(2), '0);
      send_request(cpra_pkg::KIND_FREE, '0, 20'h00005);
      send_request(cpra_pkg::KIND_FREE, '0, 20'h00004);
      send_request(cpra_pkg::KIND_ALLOC, cpra_pkg::count_type'(3), '0);
      send_request(cpra_pkg::KIND_FREE, '0, 20'h00007);
      send_request(cpra_pkg::KIND_ALLOC, cpra_pkg::count_type'(5000), '0);
      send_request(cpra_pkg::KIND_ALLOC, cpra_pkg::count_type'(6), '0);
      send_request(cpra_pkg::KIND_ALLOC, cpra_pkg::count_type'(1), '0);
      send_request(cpra_pkg::KIND_FREE, '0, 20'h00006);
      send_request(cpra_pkg::KIND_FREE, '0, 20'h01000);
      send_request(cpra_pkg::KIND_FREE, '0, 20'hFFFFF);
      send_request(cpra_pkg::KIND_FREE, '0, 20'h00000);
      send_request(cpra_pkg::KIND_FREE, '0, 20'h00007);

      // Random phases over several register settings
      random_items(500);
      configure(20'h00000, 20'h00008, 20'h0000F);
      random_items(450);
      configure(20'hFFF80, 20'h00010, 20'h0001F);
      random_items(100);
      configure(20'h12345, 20'hFFFFF, 20'h00000);
      random_items(400);
      configure(20'hFFFFF, 20'h00000, 20'hFFFFF);
      random_items(12);
      configure(20'h00100, 20'h00200, 20'h002FF);
      random_items(300);

      // Drain and allow for trailing activity
      wait_idle();
      repeat (64) @(negedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
